/* sv/gbc_pkg.sv */
// Shared types and constants for the clamped-window Gaussian blur.
// No dependencies; imported by every module of the block.
package gbc_pkg;

    // Largest frame height the row counters cover
    localparam int MAX_HEIGHT = 4096;
    // Width of one channel accumulator
    localparam int ACC_W = 32;
    // Width of one tap weight after the Q0.16 product shift
    localparam int TW_W = 16;

    // Configuration register indexes
    localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [2:0] REG_BLUR_RADIUS   = 3'd3;
    localparam logic [2:0] REG_WEIGHT_CENTER = 3'd4;
    localparam logic [2:0] REG_WEIGHT_ONE    = 3'd5;
    localparam logic [2:0] REG_WEIGHT_TWO    = 3'd6;
    localparam logic [2:0] REG_WEIGHT_THREE  = 3'd7;

    // Input request kinds
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_TAP,
        ST_TAIL,
        ST_ADVANCE,
        ST_DECIDE,
        ST_OUT
    } gbc_state_t;

    // Accumulator control shared by all lanes
    typedef struct packed {
        logic clear;
        logic enable;
    } lane_ctrl_t;

endpackage

/* sv/gbc_lane.sv */
// One channel multiply-accumulate lane of the blur window.
// Depends on gbc_pkg for the accumulator and tap weight widths.
module gbc_lane (
    input  logic                     clk,
    input  logic                     rst_n,
    input  gbc_pkg::lane_ctrl_t      ctrl,
    input  logic [7:0]               sample,
    input  logic [gbc_pkg::TW_W-1:0] tap_weight,
    output logic [gbc_pkg::ACC_W-1:0] acc
);
    import gbc_pkg::*;

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;

    // Clear at window start, add one weighted tap per valid cycle
    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.enable)
        begin
            acc_next = acc_reg + ACC_W'(ACC_W'(sample) * ACC_W'(tap_weight));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

/* sv/gbc_merge.sv */
// Merging stage: rounds and saturates the lane sums into output bytes.
// Depends on gbc_pkg for the accumulator width.
module gbc_merge #(
    parameter int LANES = 4
) (
    input  logic [gbc_pkg::ACC_W-1:0] acc [LANES],
    input  logic [2:0]                chans,
    output logic [31:0]               pixel
);
    import gbc_pkg::*;

    logic [ACC_W:0]    rounded [LANES];
    logic [ACC_W-16:0] scaled  [LANES];

    // Round to nearest, drop the Q0.16 fraction, clamp to a byte
    always_comb
    begin
        pixel = '0;
        for (int c = 0; c < LANES; c++)
        begin
            rounded[c] = {1'b0, acc[c]} + (ACC_W + 1)'(32768);
            scaled[c]  = rounded[c][ACC_W:16];
            if (c < int'(chans))
            begin
                if (scaled[c] > (ACC_W - 15)'(255))
                begin
                    pixel[8*c +: 8] = 8'hFF;
                end
                else
                begin
                    pixel[8*c +: 8] = scaled[c][7:0];
                end
            end
        end
    end

endmodule

/* sv/gaussian_blur_clamped_window_top.sv */
// Top level of the clamped-window Gaussian blur: register file, line store,
// tap sequencer and output register. Depends on gbc_pkg, gbc_lane, gbc_merge.
//
// Usage: pixels enter in raster order on the s_ channel, one request each;
// tuser selects a pixel (0) or a drain request (1). A pixel is written into a
// line store of 2*MAX_RADIUS+1 rows, then every output whose window is
// complete is produced, up to r+1 per pixel request and one per drain
// request. Results leave on the m_ channel in raster order; tlast marks the
// last result of a request, tuser marks the last pixel of the frame.
// Each result walks its (2r+1)^2 window one tap per cycle through the single
// read port of the line store, while LANES channel lanes accumulate side by
// side; after the request is taken, each result passes the states CHECK, TAP,
// TAIL, ADVANCE and DECIDE and is then held in OUT; further results follow
// while the receiver keeps up, and a new request is taken once the last result
// is delivered (after CHECK for a request that yields none).
// The block accepts no request while a result is held for the receiver; a
// stall on m_tready simply holds the output register.
// Reset clears the cursors and loads the default registers; the line store
// holds no reset value, and only entries of the current frame are read.
// Writing frame_width, frame_height or blur_radius restarts the frame only while the sequencer is idle.
module gaussian_blur_clamped_window_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_RADIUS = 3,
    parameter int LANES      = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // Config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // in_chan0, in_chan1, in_chan2, in_chan3
    input  logic        s_tuser,   // action
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_chan0, out_chan1, out_chan2, out_chan3
    output logic        m_tlast,
    output logic        m_tuser    // frame_end
);
    import gbc_pkg::*;

    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int RW        = $clog2(MAX_RADIUS + 1);
    localparam int ROW_SLOTS = 2 * MAX_RADIUS + 1;
    localparam int SW        = $clog2(ROW_SLOTS);
    localparam int DEPTH     = ROW_SLOTS * MAX_WIDTH;
    localparam int AW        = $clog2(DEPTH);
    localparam int HW        = $clog2(MAX_HEIGHT);
    localparam int MEM_W     = 8 * LANES;
    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);

    // Registers
    logic [11:0]  width_reg;
    logic [12:0]  height_reg;
    logic [2:0]   chans_reg;
    logic [1:0]   radius_reg;
    logic [15:0]  wgt_reg [4];

    // Sequencer state
    gbc_state_t   state_reg, state_next;
    logic [CW-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [HW-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [SW-1:0] in_slot_reg, in_slot_next, out_slot_reg, out_slot_next;
    logic          done_reg, done_next;
    logic [RW:0]   limit_reg, limit_next, count_reg, count_next;
    logic signed [RW:0] dy_reg, dy_next, dx_reg, dx_next;
    logic          data_v_reg, data_v_next;
    logic [TW_W-1:0] tw_reg, tw_next;
    logic [31:0]   pix_reg, pix_next;
    logic          fend_reg, fend_next;
    logic          last_reg, last_next;

    // Line store
    logic [MEM_W-1:0] line_mem [DEPTH];
    logic [MEM_W-1:0] rd_data_reg;

    // Decoded values
    logic [CW-1:0] wm1;
    logic [HW-1:0] hm1;
    logic [2:0]    chans_eff;
    logic [RW-1:0] rad;
    logic          ready_now;
    logic          cfg_wr, cfg_restart;
    logic          in_fire, out_fire;
    logic          mem_we;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [MEM_W-1:0] wr_word;
    lane_ctrl_t    lane_ctrl;
    logic [ACC_W-1:0] acc [LANES];
    logic [31:0]   merged;
    logic          frame_last;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign cfg_restart = cfg_wr && ((paddr[4:2] == REG_FRAME_WIDTH) ||
                         (paddr[4:2] == REG_FRAME_HEIGHT) ||
                         (paddr[4:2] == REG_BLUR_RADIUS));

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 12'd640;
            height_reg <= 13'd480;
            chans_reg  <= 3'd3;
            radius_reg <= 2'd1;
            wgt_reg[0] <= 16'hFFFF;
            wgt_reg[1] <= '0;
            wgt_reg[2] <= '0;
            wgt_reg[3] <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_FRAME_WIDTH:   width_reg  <= pwdata[11:0];
                REG_FRAME_HEIGHT:  height_reg <= pwdata[12:0];
                REG_CHANNEL_COUNT: chans_reg  <= pwdata[2:0];
                REG_BLUR_RADIUS:   radius_reg <= pwdata[1:0];
                REG_WEIGHT_CENTER: wgt_reg[0] <= pwdata[15:0];
                REG_WEIGHT_ONE:    wgt_reg[1] <= pwdata[15:0];
                REG_WEIGHT_TWO:    wgt_reg[2] <= pwdata[15:0];
                REG_WEIGHT_THREE:  wgt_reg[3] <= pwdata[15:0];
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (paddr[4:2])
            REG_FRAME_WIDTH:   prdata = {20'd0, width_reg};
            REG_FRAME_HEIGHT:  prdata = {19'd0, height_reg};
            REG_CHANNEL_COUNT: prdata = {29'd0, chans_reg};
            REG_BLUR_RADIUS:   prdata = {30'd0, radius_reg};
            REG_WEIGHT_CENTER: prdata = {16'd0, wgt_reg[0]};
            REG_WEIGHT_ONE:    prdata = {16'd0, wgt_reg[1]};
            REG_WEIGHT_TWO:    prdata = {16'd0, wgt_reg[2]};
            REG_WEIGHT_THREE:  prdata = {16'd0, wgt_reg[3]};
            default:           prdata = '0;
        endcase
    end

    // Clamp the shape registers to their working ranges
    always_comb
    begin
        int w_i;
        int h_i;
        int c_i;
        int r_i;
        w_i = int'(width_reg);
        h_i = int'(height_reg);
        c_i = int'(chans_reg);
        r_i = int'(radius_reg);
        if (w_i < 1) w_i = 1;
        if (w_i > MAX_WIDTH) w_i = MAX_WIDTH;
        if (h_i < 1) h_i = 1;
        if (h_i > MAX_HEIGHT) h_i = MAX_HEIGHT;
        if (c_i < 1) c_i = 1;
        if (c_i > LANES) c_i = LANES;
        if (r_i > MAX_RADIUS) r_i = MAX_RADIUS;
        wm1       = CW'(w_i - 1);
        hm1       = HW'(h_i - 1);
        chans_eff = 3'(c_i);
        rad       = RW'(r_i);
    end

    // Window of the next output fully arrived
    always_comb
    begin
        logic [HW:0] need_row;
        logic [CW:0] need_col;
        need_row = {1'b0, out_row_reg} + (HW + 1)'(rad);
        if (need_row > {1'b0, hm1}) need_row = {1'b0, hm1};
        need_col = {1'b0, out_col_reg} + (CW + 1)'(rad);
        if (need_col > {1'b0, wm1}) need_col = {1'b0, wm1};
        ready_now = done_reg ||
                    ({1'b0, in_row_reg} > need_row) ||
                    (({1'b0, in_row_reg} == need_row) && ({1'b0, in_col_reg} > need_col));
    end

    // Tap address with edge clamping, and the tap weight
    always_comb
    begin
        logic signed [HW+1:0] yy;
        logic signed [CW+1:0] xx;
        logic signed [HW+1:0] dlt;
        logic signed [SW+1:0] slot_s;
        logic [RW-1:0] ay;
        logic [RW-1:0] ax;
        logic [15:0]   wa;
        logic [15:0]   wb;
        logic [31:0]   prod;
        yy = $signed({2'b00, out_row_reg}) + (HW + 2)'(dy_reg);
        if (yy < 0) yy = '0;
        if (yy > $signed({2'b00, hm1})) yy = $signed({2'b00, hm1});
        xx = $signed({2'b00, out_col_reg}) + (CW + 2)'(dx_reg);
        if (xx < 0) xx = '0;
        if (xx > $signed({2'b00, wm1})) xx = $signed({2'b00, wm1});
        dlt    = yy - $signed({2'b00, out_row_reg});
        slot_s = $signed({2'b00, out_slot_reg}) + (SW + 2)'(dlt);
        if (slot_s < 0)
        begin
            slot_s = slot_s + (SW + 2)'(ROW_SLOTS);
        end
        else if (slot_s >= (SW + 2)'(ROW_SLOTS))
        begin
            slot_s = slot_s - (SW + 2)'(ROW_SLOTS);
        end
        rd_addr = AW'(slot_s[SW-1:0]) * ROW_STRIDE + AW'(xx[CW-1:0]);

        ay = (dy_reg < 0) ? RW'(-dy_reg) : RW'(dy_reg);
        ax = (dx_reg < 0) ? RW'(-dx_reg) : RW'(dx_reg);
        wa = '0;
        wb = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (int'(ay) == k) wa = wgt_reg[k];
            if (int'(ax) == k) wb = wgt_reg[k];
        end
        prod    = wa * wb;
        tw_next = prod[31:16];
    end

    // Pixel word written into the store
    always_comb
    begin
        wr_word = s_tdata[MEM_W-1:0];
        wr_addr = AW'(in_slot_reg) * ROW_STRIDE + AW'(in_col_reg);
    end

    assign frame_last = (out_row_reg >= hm1) && (out_col_reg >= wm1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire) state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if ((count_reg < limit_reg) && ready_now) state_next = ST_TAP;
                else state_next = ST_IDLE;
            end
            ST_TAP:
            begin
                if ((dx_reg == $signed({1'b0, rad})) && (dy_reg == $signed({1'b0, rad})))
                    state_next = ST_TAIL;
            end
            ST_TAIL:
            begin
                if (!data_v_reg) state_next = ST_ADVANCE;
            end
            ST_ADVANCE: state_next = ST_DECIDE;
            ST_DECIDE:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_fire) state_next = last_reg ? ST_IDLE : ST_CHECK;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        s_tready         = (state_reg == ST_IDLE);
        m_tvalid         = (state_reg == ST_OUT);
        mem_we           = in_fire && (s_tuser == ACT_PIXEL) && !done_reg;
        lane_ctrl.clear  = (state_reg == ST_CHECK);
        lane_ctrl.enable = data_v_reg;
    end

    // Cursors, counters and result register
    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_slot_next  = in_slot_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        done_next     = done_reg;
        limit_next    = limit_reg;
        count_next    = count_reg;
        dy_next       = dy_reg;
        dx_next       = dx_reg;
        data_v_next   = (state_reg == ST_TAP);
        pix_next      = pix_reg;
        fend_next     = fend_reg;
        last_next     = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_restart)
                begin
                    in_col_next   = '0;
                    in_row_next   = '0;
                    in_slot_next  = '0;
                    out_col_next  = '0;
                    out_row_next  = '0;
                    out_slot_next = '0;
                    done_next     = 1'b0;
                end
                else if (in_fire)
                begin
                    count_next = '0;
                    limit_next = (s_tuser == ACT_PIXEL) ? ((RW + 1)'(rad) + (RW + 1)'(1))
                                                        : (RW + 1)'(1);
                    if (mem_we)
                    begin
                        if (in_col_reg >= wm1)
                        begin
                            in_col_next = '0;
                            if (in_row_reg >= hm1)
                            begin
                                in_row_next  = '0;
                                in_slot_next = '0;
                                done_next    = 1'b1;
                            end
                            else
                            begin
                                in_row_next  = in_row_reg + HW'(1);
                                in_slot_next = (in_slot_reg == SW'(ROW_SLOTS - 1))
                                               ? '0 : in_slot_reg + SW'(1);
                            end
                        end
                        else
                        begin
                            in_col_next = in_col_reg + CW'(1);
                        end
                    end
                end
            end
            ST_CHECK:
            begin
                dy_next = -$signed({1'b0, rad});
                dx_next = -$signed({1'b0, rad});
            end
            ST_TAP:
            begin
                // Walk the window row by row
                if (dx_reg == $signed({1'b0, rad}))
                begin
                    dx_next = -$signed({1'b0, rad});
                    dy_next = dy_reg + (RW + 1)'(1);
                end
                else
                begin
                    dx_next = dx_reg + (RW + 1)'(1);
                end
            end
            ST_ADVANCE:
            begin
                pix_next   = merged;
                fend_next  = frame_last;
                count_next = count_reg + (RW + 1)'(1);
                if (frame_last)
                begin
                    in_col_next   = '0;
                    in_row_next   = '0;
                    in_slot_next  = '0;
                    out_col_next  = '0;
                    out_row_next  = '0;
                    out_slot_next = '0;
                    done_next     = 1'b0;
                end
                else if (out_col_reg >= wm1)
                begin
                    out_col_next  = '0;
                    out_row_next  = out_row_reg + HW'(1);
                    out_slot_next = (out_slot_reg == SW'(ROW_SLOTS - 1))
                                    ? '0 : out_slot_reg + SW'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
            ST_DECIDE:
            begin
                last_next = !((count_reg < limit_reg) && ready_now);
            end
            default:
            begin
                pix_next = pix_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            done_reg     <= 1'b0;
            limit_reg    <= '0;
            count_reg    <= '0;
            dy_reg       <= '0;
            dx_reg       <= '0;
            data_v_reg   <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_slot_reg  <= in_slot_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_slot_reg <= out_slot_next;
            done_reg     <= done_next;
            limit_reg    <= limit_next;
            count_reg    <= count_next;
            dy_reg       <= dy_next;
            dx_reg       <= dx_next;
            data_v_reg   <= data_v_next;
            last_reg     <= last_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tw_reg   <= tw_next;
        pix_reg  <= pix_next;
        fend_reg <= fend_next;
    end

    // Line store: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[wr_addr] <= wr_word;
        end
        rd_data_reg <= line_mem[rd_addr];
    end

    // Channel lanes
    for (genvar c = 0; c < LANES; c++)
    begin : g_lane
        gbc_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (lane_ctrl),
            .sample     (rd_data_reg[8*c +: 8]),
            .tap_weight (tw_reg),
            .acc        (acc[c])
        );
    end

    gbc_merge #(
        .LANES (LANES)
    ) u_merge (
        .acc    (acc),
        .chans  (chans_eff),
        .pixel  (merged)
    );

    assign m_tdata = pix_reg;
    assign m_tuser = fend_reg;
    assign m_tlast = last_reg;

endmodule

/* sim/gbc_blur_checker.sv */
// Checker for the clamped-window Gaussian blur: follows register writes and
// accepted requests, predicts blurred pixels and compares them on the m_ channel.
// Depends on gbc_pkg for register indexes and request kinds.
`timescale 1ns / 100ps

module gbc_blur_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    input  logic        m_tuser,
    output int          error_count,
    output int          pending_count,
    output logic        frame_busy
);
    import gbc_pkg::*;

    localparam int MAX_W = 2048;
    localparam int ROWS  = 7;

    typedef struct {
        logic [31:0] pix;
        logic        frame_end;
        logic        run_last;
    } blur_pixel_t;

    blur_pixel_t  blurred_q[$];
    logic [31:0]  line_mem [0:ROWS*MAX_W-1];
    logic [31:0]  cfg [0:7];
    int unsigned  in_col, in_row, out_col, out_row;
    logic         frame_in_done;

    function automatic int unsigned cfg_width();
        int unsigned v;
        v = cfg[REG_FRAME_WIDTH];
        if (v < 1) v = 1;
        if (v > MAX_W) v = MAX_W;
        return v;
    endfunction

    function automatic int unsigned cfg_height();
        int unsigned v;
        v = cfg[REG_FRAME_HEIGHT];
        if (v < 1) v = 1;
        if (v > MAX_HEIGHT) v = MAX_HEIGHT;
        return v;
    endfunction

    function automatic int unsigned cfg_chans();
        int unsigned v;
        v = cfg[REG_CHANNEL_COUNT];
        if (v < 1) v = 1;
        if (v > 4) v = 4;
        return v;
    endfunction

    function automatic int unsigned cfg_radius();
        return cfg[REG_BLUR_RADIUS];
    endfunction

    function automatic logic window_complete();
        int unsigned need_row, need_col;
        if (frame_in_done) return 1'b1;
        need_row = out_row + cfg_radius();
        if (need_row > cfg_height() - 1) need_row = cfg_height() - 1;
        need_col = out_col + cfg_radius();
        if (need_col > cfg_width() - 1) need_col = cfg_width() - 1;
        return (in_row > need_row) || (in_row == need_row && in_col > need_col);
    endfunction

    task automatic restart_cursors();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        frame_in_done = 1'b0;
    endtask

    // Blur the pixel at the output cursor and advance it
    task automatic blur_next_pixel();
        longint unsigned acc [4];
        longint unsigned tap_w, v;
        int              yy, xx, rad, w, h;
        logic [31:0]     word;
        blur_pixel_t     res;
        rad = cfg_radius();
        w = cfg_width();
        h = cfg_height();
        for (int c = 0; c < 4; c++) acc[c] = 0;
        for (int dy = -rad; dy <= rad; dy++)
        begin
            yy = out_row + dy;
            if (yy < 0) yy = 0;
            if (yy > h - 1) yy = h - 1;
            for (int dx = -rad; dx <= rad; dx++)
            begin
                xx = out_col + dx;
                if (xx < 0) xx = 0;
                if (xx > w - 1) xx = w - 1;
                tap_w = (longint'(cfg[REG_WEIGHT_CENTER + (dy < 0 ? -dy : dy)])
                       * longint'(cfg[REG_WEIGHT_CENTER + (dx < 0 ? -dx : dx)])) >> 16;
                word = line_mem[(yy % ROWS) * MAX_W + xx];
                for (int c = 0; c < 4; c++)
                    acc[c] += longint'(word[8*c +: 8]) * tap_w;
            end
        end
        res.pix = '0;
        for (int c = 0; c < 4; c++)
        begin
            v = (acc[c] + 32768) >> 16;
            if (v > 255) v = 255;
            if (c < cfg_chans()) res.pix[8*c +: 8] = v[7:0];
        end
        res.frame_end = (out_row >= h - 1) && (out_col >= w - 1);
        res.run_last = 1'b0;
        blurred_q.push_back(res);
        if (res.frame_end)
            restart_cursors();
        else if (out_col + 1 >= w)
        begin
            out_col = 0;
            out_row++;
        end
        else
            out_col++;
    endtask

    // Store a pixel if the frame still wants it, then emit ready results
    task automatic take_request(input logic act, input logic [31:0] px);
        int unsigned limit, count;
        count = 0;
        if (act == ACT_PIXEL)
        begin
            limit = cfg_radius() + 1;
            if (!frame_in_done)
            begin
                line_mem[(in_row % ROWS) * MAX_W + in_col] = px;
                if (in_col + 1 >= cfg_width())
                begin
                    in_col = 0;
                    if (in_row + 1 >= cfg_height())
                    begin
                        in_row = 0;
                        frame_in_done = 1'b1;
                    end
                    else
                        in_row++;
                end
                else
                    in_col++;
            end
        end
        else
            limit = 1;
        while (count < limit && window_complete())
        begin
            blur_next_pixel();
            count++;
        end
        if (count > 0) blurred_q[$].run_last = 1'b1;
    endtask

    // Track registers and requests, check results
    always @(posedge clk or negedge rst_n)
    begin
        blur_pixel_t got;
        if (!rst_n)
        begin
            cfg[0] = 640; cfg[1] = 480; cfg[2] = 3; cfg[3] = 1;
            cfg[4] = 65535; cfg[5] = 0; cfg[6] = 0; cfg[7] = 0;
            restart_cursors();
            blurred_q.delete();
            error_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_FRAME_WIDTH:   cfg[REG_FRAME_WIDTH] = pwdata[11:0];
                    REG_FRAME_HEIGHT:  cfg[REG_FRAME_HEIGHT] = pwdata[12:0];
                    REG_CHANNEL_COUNT: cfg[REG_CHANNEL_COUNT] = pwdata[2:0];
                    REG_BLUR_RADIUS:   cfg[REG_BLUR_RADIUS] = pwdata[1:0];
                    default:           cfg[paddr[4:2]] = pwdata[15:0];
                endcase
                if (paddr[4:2] inside {REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_BLUR_RADIUS})
                    restart_cursors();
            end
            if (m_tvalid && m_tready)
            begin
                if (blurred_q.size() == 0)
                begin
                    $display("%0t: unexpected result data=%h last=%b end=%b",
                             $time, m_tdata, m_tlast, m_tuser);
                    error_count++;
                end
                else
                begin
                    got = blurred_q.pop_front();
                    if (got.pix !== m_tdata || got.run_last !== m_tlast
                        || got.frame_end !== m_tuser)
                    begin
                        $display("%0t: expected data=%h last=%b end=%b, got data=%h last=%b end=%b",
                                 $time, got.pix, got.run_last, got.frame_end,
                                 m_tdata, m_tlast, m_tuser);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                take_request(s_tuser, s_tdata);
        end
        pending_count = blurred_q.size();
        frame_busy = frame_in_done || in_col != 0 || in_row != 0
                     || out_col != 0 || out_row != 0;
    end

endmodule

/* sim/gaussian_blur_clamped_window_top_test.sv */
// Stimulus and verdict for the clamped-window Gaussian blur: frames of random
// shape, weights and pixels under random stalls. Depends on gbc_pkg, the block
// and gbc_blur_checker.
`timescale 1ns / 100ps

module gaussian_blur_clamped_window_top_test;
    import gbc_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast, m_tuser;

    int          error_count, pending_count;
    logic        frame_busy;
    logic        stall_on = 1'b1;
    logic        hold_req = 1'b0;
    int          hold_cycles = 0;
    int          sent = 0;

    always #5 clk = ~clk;

    gaussian_blur_clamped_window_top u_top (.*);

    gbc_blur_checker u_check (.*);

    // Drive the receiver: random back-pressure, or a long hold when asked
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cycles = 400;
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready = 1'b0;
            end
            else
                m_tready = !stall_on || ($urandom_range(99) >= 27);
        end
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // Offer one request and hold it until accepted
    task automatic send_request(input logic act, input logic [31:0] px);
        while (stall_on && $urandom_range(99) < 27)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1; s_tuser = act; s_tdata = px;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        sent++;
    endtask

    // Pause until every expected result is out and the sequencer has settled
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic set_shape(input int w, input int h, input int chans, input int rad,
                             input int w0, input int w1, input int w2, input int w3);
        cfg_write(REG_FRAME_WIDTH, w);
        cfg_write(REG_FRAME_HEIGHT, h);
        cfg_write(REG_CHANNEL_COUNT, chans);
        cfg_write(REG_BLUR_RADIUS, rad);
        cfg_write(REG_WEIGHT_CENTER, w0);
        cfg_write(REG_WEIGHT_ONE, w1);
        cfg_write(REG_WEIGHT_TWO, w2);
        cfg_write(REG_WEIGHT_THREE, w3);
    endtask

    // Feed one frame with drains mixed in, then flush it unless told not to
    task automatic run_frame(input int npix, input logic flush);
        int n;
        n = 0;
        while (n < npix)
        begin
            if ($urandom_range(9) == 0)
                send_request(ACT_DRAIN, $urandom);
            else
            begin
                send_request(ACT_PIXEL, $urandom);
                n++;
            end
        end
        n = 0;
        while (flush && frame_busy && n < 200)
        begin
            send_request(ACT_DRAIN, $urandom);
            n++;
        end
        wait_drained();
    endtask

    initial
    begin
        int w, h, rad, wmax;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Drain with nothing ready under the default shape
        send_request(ACT_DRAIN, 32'h0);
        wait_drained();

        // Full weights at the widest radius: saturate every lane
        set_shape(4, 3, 4, 3, 65535, 65535, 65535, 65535);
        for (int i = 0; i < 12; i++)
            send_request(ACT_PIXEL, (i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000);
        // Pixels after the frame is complete only flush results
        send_request(ACT_PIXEL, 32'h1234_5678);
        send_request(ACT_PIXEL, 32'hFFFF_FFFF);
        for (int i = 0; i < 6; i++) send_request(ACT_DRAIN, 32'hFFFF_FFFF);
        wait_drained();

        // Zero weights, zero-coded shape registers, channel count over the limit
        set_shape(0, 0, 7, 0, 0, 0, 0, 0);
        send_request(ACT_PIXEL, 32'hFFFF_FFFF);
        send_request(ACT_DRAIN, 32'h0);
        wait_drained();

        // Widest frame register with one row, then the tallest, each partly fed then restarted
        set_shape(4095, 1, 0, 0, 40000, 12000, 3000, 500);
        run_frame(30, 1'b0);
        set_shape(2, 8191, 2, 0, 65535, 0, 0, 0);
        run_frame(20, 1'b0);

        // Receiver holds off while the sender keeps offering
        set_shape(6, 5, 3, 2, 30000, 12000, 6000, 2000);
        hold_req = 1'b1;
        run_frame(30, 1'b1);

        // Random frames, with one long stretch free of stalls
        while (sent < 450)
        begin
            stall_on = !(sent > 250 && sent < 330);
            w = ($urandom_range(9) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 8);
            h = $urandom_range(0, 6);
            rad = $urandom_range(0, 3);
            wmax = ($urandom_range(2) == 0) ? 65535 : 20000;
            set_shape(w, h, $urandom_range(0, 7), rad,
                      $urandom_range(0, wmax), $urandom_range(0, wmax),
                      $urandom_range(0, wmax), $urandom_range(0, wmax));
            if (w < 1) w = 1;
            if (h < 1) h = 1;
            run_frame(w * h + $urandom_range(0, 3), $urandom_range(3) != 0);
            // Weights and channel count change without a restart
            if ($urandom_range(3) == 0)
            begin
                cfg_write(REG_CHANNEL_COUNT, $urandom_range(1, 4));
                cfg_write(REG_WEIGHT_ONE, $urandom_range(0, 65535));
                run_frame(w, 1'b1);
            end
        end

        wait_drained();
        repeat (100) @(negedge clk);
        if (error_count == 0)
            $display("gaussian_blur_clamped_window_top test passed");
        else
            $display("gaussian_blur_clamped_window_top test failed");
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #10_000_000;
        $display("gaussian_blur_clamped_window_top test failed");
        $finish;
    end

endmodule
